// ----- sv/cpg_pkg.sv -----
// Shared types, constants and helper functions for the circle point generator.
`default_nettype none

package cpg_pkg;

   localparam int unsigned COORD_W  = 16;
   localparam int unsigned COLOR_W  = 16;
   localparam int unsigned RADIUS_W = 9;

   localparam int unsigned ANGLE_STEPS_DEF    = 27;
   localparam int unsigned TRIG_FRAC_BITS_DEF = 16;

   // Working precision of the series used to build the trig tables.
   localparam int unsigned WORK_BITS = 30;

   localparam int unsigned POINTS_PER_STEP = 8;
   localparam int unsigned POINT_IDX_W     = $clog2(POINTS_PER_STEP);
   localparam logic [POINT_IDX_W-1:0] LAST_POINT = POINT_IDX_W'(POINTS_PER_STEP - 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef struct packed {
      logic                valid;
      logic [COORD_W-1:0]  cx;
      logic [COORD_W-1:0]  cy;
      logic [RADIUS_W-1:0] dx;
      logic [RADIUS_W-1:0] dy;
      logic [COLOR_W-1:0]  color;
      logic                done;
   } job_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   // Previous series term times the squared angle, before its divisor is applied.
   function automatic logic [63:0] series_term(logic [63:0] prev, logic [63:0] a2);
      return (prev * a2) >> WORK_BITS;
   endfunction

   function automatic logic [63:0] floor_sub(logic [63:0] sum, logic [63:0] term);
      return (sum >= term) ? sum - term : 64'd0;
   endfunction

   // Sine or cosine of k * 0.03 rad, rounded to frac_bits fraction bits.
   // Evaluated only at elaboration to fill the angle tables.
   function automatic logic [63:0] trig_value(int unsigned k, int unsigned frac_bits,
                                              bit want_cos);
      logic [63:0] one;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] st;
      logic [63:0] ct;
      logic [63:0] s;
      logic [63:0] c;
      logic [63:0] half;
      int unsigned sh;
      one  = 64'd1 << WORK_BITS;
      a    = (64'(k) * 64'd3 * one + 64'd50) / 64'd100;
      a2   = (a * a) >> WORK_BITS;
      st   = a;
      ct   = one;
      s    = a;
      c    = one;
      sh   = WORK_BITS - frac_bits;
      half = 64'd1 << (sh - 1);
      // Twelve terms; odd terms are subtracted and floored at zero, even terms added.
      st = series_term(st, a2) / 64'd6;     s = floor_sub(s, st);
      ct = series_term(ct, a2) / 64'd2;     c = floor_sub(c, ct);
      st = series_term(st, a2) / 64'd20;    s = s + st;
      ct = series_term(ct, a2) / 64'd12;    c = c + ct;
      st = series_term(st, a2) / 64'd42;    s = floor_sub(s, st);
      ct = series_term(ct, a2) / 64'd30;    c = floor_sub(c, ct);
      st = series_term(st, a2) / 64'd72;    s = s + st;
      ct = series_term(ct, a2) / 64'd56;    c = c + ct;
      st = series_term(st, a2) / 64'd110;   s = floor_sub(s, st);
      ct = series_term(ct, a2) / 64'd90;    c = floor_sub(c, ct);
      st = series_term(st, a2) / 64'd156;   s = s + st;
      ct = series_term(ct, a2) / 64'd132;   c = c + ct;
      st = series_term(st, a2) / 64'd210;   s = floor_sub(s, st);
      ct = series_term(ct, a2) / 64'd182;   c = floor_sub(c, ct);
      st = series_term(st, a2) / 64'd272;   s = s + st;
      ct = series_term(ct, a2) / 64'd240;   c = c + ct;
      st = series_term(st, a2) / 64'd342;   s = floor_sub(s, st);
      ct = series_term(ct, a2) / 64'd306;   c = floor_sub(c, ct);
      st = series_term(st, a2) / 64'd420;   s = s + st;
      ct = series_term(ct, a2) / 64'd380;   c = c + ct;
      st = series_term(st, a2) / 64'd506;   s = floor_sub(s, st);
      ct = series_term(ct, a2) / 64'd462;   c = floor_sub(c, ct);
      st = series_term(st, a2) / 64'd600;   s = s + st;
      ct = series_term(ct, a2) / 64'd552;   c = c + ct;
      return want_cos ? ((c + half) >> sh) : ((s + half) >> sh);
   endfunction

   // Eight-way symmetry: bit 2 swaps the offsets, bits 0 and 1 negate x and y.
   function automatic point_type point_of(logic [POINT_IDX_W-1:0] idx, job_type job);
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      point_type          pt;
      ox   = idx[2] ? COORD_W'(job.dy) : COORD_W'(job.dx);
      oy   = idx[2] ? COORD_W'(job.dx) : COORD_W'(job.dy);
      pt.x = idx[0] ? job.cx - ox : job.cx + ox;
      pt.y = idx[1] ? job.cy - oy : job.cy + oy;
      return pt;
   endfunction

endpackage

`default_nettype wire

// ----- sv/cpg_step_unit.sv -----
// Circle state, angle tables and offset multipliers feeding the job register.
`default_nettype none

module cpg_step_unit #(
   parameter int unsigned ANGLE_STEPS    = cpg_pkg::ANGLE_STEPS_DEF,
   parameter int unsigned TRIG_FRAC_BITS = cpg_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_operation,
   input  wire logic [cpg_pkg::COORD_W-1:0]   req_center_x,
   input  wire logic [cpg_pkg::COORD_W-1:0]   req_center_y,
   input  wire logic [cpg_pkg::RADIUS_W-1:0]  req_radius,
   input  wire logic [cpg_pkg::COLOR_W-1:0]   req_color,
   input  wire logic                          job_take,
   output cpg_pkg::job_type                   job
);

   localparam int unsigned TW = TRIG_FRAC_BITS + 1;
   localparam int unsigned AW = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
   localparam int unsigned PW = cpg_pkg::RADIUS_W + TW;
   localparam logic [AW-1:0] LAST_ANGLE = AW'(ANGLE_STEPS - 1);

   logic [TW-1:0] sin_tab [ANGLE_STEPS];
   logic [TW-1:0] cos_tab [ANGLE_STEPS];

   for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rom
      localparam logic [TW-1:0] SIN_VAL = TW'(cpg_pkg::trig_value(g, TRIG_FRAC_BITS, 1'b0));
      localparam logic [TW-1:0] COS_VAL = TW'(cpg_pkg::trig_value(g, TRIG_FRAC_BITS, 1'b1));
      assign sin_tab[g] = SIN_VAL;
      assign cos_tab[g] = COS_VAL;
   end

   logic [cpg_pkg::COORD_W-1:0]  cx_ff,     cx_in;
   logic [cpg_pkg::COORD_W-1:0]  cy_ff,     cy_in;
   logic [cpg_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [cpg_pkg::COLOR_W-1:0]  color_ff,  color_in;
   logic [AW-1:0]                angle_ff,  angle_in;
   logic                         active_ff, active_in;
   cpg_pkg::job_type             job_ff,    job_in;

   logic          accept;
   logic          last_angle;
   logic [PW-1:0] sin_prod;
   logic [PW-1:0] cos_prod;

   assign req_stall  = job_ff.valid && !job_take;
   assign accept     = req_valid && !req_stall;
   assign last_angle = (angle_ff == LAST_ANGLE);
   assign sin_prod   = PW'(radius_ff) * PW'(sin_tab[angle_ff]);
   assign cos_prod   = PW'(radius_ff) * PW'(cos_tab[angle_ff]);
   assign job        = job_ff;

   always_comb begin
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      radius_in    = radius_ff;
      color_in     = color_ff;
      angle_in     = angle_ff;
      active_in    = active_ff;
      job_in       = job_ff;
      job_in.valid = job_ff.valid && !job_take;
      if (accept) begin
         if (req_operation == cpg_pkg::OP_START) begin
            cx_in     = req_center_x;
            cy_in     = req_center_y;
            radius_in = req_radius;
            color_in  = req_color;
            angle_in  = '0;
            active_in = 1'b1;
         end else if (active_ff) begin
            job_in.valid = 1'b1;
            job_in.cx    = cx_ff;
            job_in.cy    = cy_ff;
            job_in.dx    = sin_prod[TRIG_FRAC_BITS +: cpg_pkg::RADIUS_W];
            job_in.dy    = cos_prod[TRIG_FRAC_BITS +: cpg_pkg::RADIUS_W];
            job_in.color = color_ff;
            job_in.done  = last_angle;
            if (last_angle) begin
               angle_in  = '0;
               active_in = 1'b0;
            end else begin
               angle_in = AW'(angle_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff        <= '0;
         cy_ff        <= '0;
         radius_ff    <= '0;
         color_ff     <= '0;
         angle_ff     <= '0;
         active_ff    <= 1'b0;
         job_ff.valid <= 1'b0;
      end else begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         radius_ff <= radius_in;
         color_ff  <= color_in;
         angle_ff  <= angle_in;
         active_ff <= active_in;
         job_ff    <= job_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/cpg_point_emitter.sv -----
// Sequencer that turns one job into eight symmetric points on the output register.
`default_nettype none

module cpg_point_emitter (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cpg_pkg::job_type             job,
   output logic                              job_take,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [cpg_pkg::COORD_W-1:0]       rsp_point_x,
   output logic [cpg_pkg::COORD_W-1:0]       rsp_point_y,
   output logic [cpg_pkg::COLOR_W-1:0]       rsp_point_color,
   output logic                              rsp_last_of_step,
   output logic                              rsp_circle_done
);

   cpg_pkg::job_type                  held_ff;
   logic [cpg_pkg::POINT_IDX_W-1:0]   idx_ff;
   logic                              busy_ff;
   logic                              valid_ff;
   logic [cpg_pkg::COORD_W-1:0]       x_ff;
   logic [cpg_pkg::COORD_W-1:0]       y_ff;
   logic [cpg_pkg::COLOR_W-1:0]       color_ff;
   logic                              last_ff;
   logic                              done_ff;

   logic                              out_free;
   logic                              load;
   logic                              last_sel;
   cpg_pkg::job_type                  src;
   logic [cpg_pkg::POINT_IDX_W-1:0]   sel;
   cpg_pkg::point_type                pt;

   // A new job starts directly with its first point, so runs follow without a gap.
   assign out_free = !valid_ff || !rsp_stall;
   assign job_take = out_free && !busy_ff && job.valid;
   assign load     = out_free && (busy_ff || job.valid);
   assign src      = busy_ff ? held_ff : job;
   assign sel      = busy_ff ? idx_ff : '0;
   assign last_sel = (sel == cpg_pkg::LAST_POINT);
   assign pt       = cpg_pkg::point_of(sel, src);

   assign rsp_valid        = valid_ff;
   assign rsp_point_x      = x_ff;
   assign rsp_point_y      = y_ff;
   assign rsp_point_color  = color_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_circle_done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (out_free) begin
            valid_ff <= load;
         end
         if (load) begin
            x_ff     <= pt.x;
            y_ff     <= pt.y;
            color_ff <= src.color;
            last_ff  <= last_sel;
            done_ff  <= last_sel && src.done;
            idx_ff   <= cpg_pkg::POINT_IDX_W'(sel + 1'b1);
            busy_ff  <= !last_sel;
         end
         if (job_take) begin
            held_ff <= job;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/circle_point_generator_core.sv -----
// Circle point generator: a start request latches center, radius and color and
// produces nothing; each step request then produces the eight symmetric points
// of the next angle of the table, ANGLE_STEPS angles 0.03 rad apart.
// Request channel: req_valid / req_stall with req_operation and the circle
// fields. Result channel: rsp_valid / rsp_stall, one point per transfer, with
// rsp_last_of_step on the eighth point and rsp_circle_done on the eighth point
// of the last angle. A step with no circle armed is taken and dropped.
// The first point of a step passes through the job register, which holds the
// offset products, and then the output register. The single output register
// sends one point per cycle while rsp_stall is low, which limits the rate of
// step requests; a job register in between
// lets the next step be taken while the current one is still emitting, and
// start requests are taken at any time the request side is not stalled.
// When the receiver stalls, the current point holds and req_stall rises once
// the job register is full. Reset is synchronous: it clears the circle state,
// disarms the generator and empties both stages; no clearing pass follows.
`default_nettype none

module circle_point_generator_core #(
   parameter int unsigned ANGLE_STEPS    = cpg_pkg::ANGLE_STEPS_DEF,
   parameter int unsigned TRIG_FRAC_BITS = cpg_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_operation,
   input  wire logic [cpg_pkg::COORD_W-1:0]   req_center_x,
   input  wire logic [cpg_pkg::COORD_W-1:0]   req_center_y,
   input  wire logic [cpg_pkg::RADIUS_W-1:0]  req_radius,
   input  wire logic [cpg_pkg::COLOR_W-1:0]   req_color,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cpg_pkg::COORD_W-1:0]        rsp_point_x,
   output logic [cpg_pkg::COORD_W-1:0]        rsp_point_y,
   output logic [cpg_pkg::COLOR_W-1:0]        rsp_point_color,
   output logic                               rsp_last_of_step,
   output logic                               rsp_circle_done
);

   cpg_pkg::job_type job;
   logic             job_take;

   cpg_step_unit #(
      .ANGLE_STEPS    (ANGLE_STEPS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .req_color     (req_color),
      .job_take      (job_take),
      .job           (job)
   );

   cpg_point_emitter u_emit (
      .clock            (clock),
      .reset            (reset),
      .job              (job),
      .job_take         (job_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_point_color  (rsp_point_color),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

   // The done flag only ever marks the closing point of a run.
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_circle_done) |-> rsp_last_of_step)
      else $error("circle_done without last_of_step");

   // Within a run the next point follows at once and keeps the color.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_step)
      |=> (rsp_valid && (rsp_point_color == $past(rsp_point_color))))
      else $error("point run broken or color changed inside a step");

   // Requests are held back only while a computed step waits for the emitter.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (job.valid && !job_take))
      else $error("request stalled without a pending step");

endmodule

`default_nettype wire
